FILE: sv/fit_policy_block_allocator_core_defines.svh
// Assertion macros shared by the allocator RTL.
`ifndef FIT_POLICY_BLOCK_ALLOCATOR_CORE_DEFINES_SVH
`define FIT_POLICY_BLOCK_ALLOCATOR_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FPBA_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("allocator check failed");

// The consequent must hold in the cycle after the antecedent.
`define FPBA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("allocator check failed");

`endif

FILE: sv/fpba_pkg.sv
`default_nettype none

package fpba_pkg;

    localparam int KIND_W     = 1;
    localparam int SLOT_W     = 4;
    localparam int ID_W       = 16;
    localparam int AMOUNT_W   = 20;
    localparam int CAP_OUT_W  = 20;
    localparam int POLICY_W   = 2;
    localparam int ACTIVE_W   = 5;
    localparam int PADDR_W    = 3;
    localparam int PDATA_W    = 32;

    localparam logic [KIND_W-1:0] KIND_LOAD    = 1'b0;
    localparam logic [KIND_W-1:0] KIND_REQUEST = 1'b1;

    localparam logic [POLICY_W-1:0] POLICY_FIRST = 2'd0;
    localparam logic [POLICY_W-1:0] POLICY_BEST  = 2'd1;
    localparam logic [POLICY_W-1:0] POLICY_WORST = 2'd2;

    localparam logic REG_FIT_POLICY   = 1'b0;
    localparam logic REG_ACTIVE_BLOCKS = 1'b1;

    localparam logic [POLICY_W-1:0] FIT_POLICY_RESET   = POLICY_FIRST;
    localparam logic [ACTIVE_W-1:0] ACTIVE_BLOCKS_RESET = 5'd16;

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [SLOT_W-1:0]   slot;
        logic [ID_W-1:0]     block_id;
        logic [AMOUNT_W-1:0] amount;
        logic [ID_W-1:0]     request_id;
    } req_t;

    typedef struct packed {
        logic [ID_W-1:0]      request_tag;
        logic                 granted;
        logic [ID_W-1:0]      chosen_block;
        logic [CAP_OUT_W-1:0] capacity_left;
    } rsp_t;

    typedef struct packed {
        logic clear;
        logic step;
    } unit_ctrl_t;

    typedef struct packed {
        logic we_cap;
        logic we_id;
    } mem_wr_t;

endpackage

`default_nettype wire

FILE: sv/fpba_slot_mem.sv
`default_nettype none

module fpba_slot_mem #(
    parameter int DEPTH = 16,
    parameter int CAP_W = 20
) (
    input  logic                        clk,
    input  fpba_pkg::mem_wr_t           wr,
    input  logic [$clog2(DEPTH)-1:0]    wr_addr,
    input  logic [CAP_W-1:0]            wr_cap,
    input  logic [fpba_pkg::ID_W-1:0]   wr_id,
    input  logic                        rd_en,
    input  logic [$clog2(DEPTH)-1:0]    rd_addr,
    output logic [CAP_W-1:0]            rd_cap,
    output logic [fpba_pkg::ID_W-1:0]   rd_id
);

    logic [CAP_W-1:0]          cap_mem [DEPTH];
    logic [fpba_pkg::ID_W-1:0] id_mem  [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr.we_cap)
        begin
            cap_mem[wr_addr] <= wr_cap;
        end
        if (wr.we_id)
        begin
            id_mem[wr_addr] <= wr_id;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_cap <= cap_mem[rd_addr];
            rd_id  <= id_mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

FILE: sv/fpba_fit_unit.sv
`default_nettype none

module fpba_fit_unit #(
    parameter int CAP_W = 20,
    parameter int IDX_W = 4
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  fpba_pkg::unit_ctrl_t            ctrl,
    input  logic [fpba_pkg::POLICY_W-1:0]   policy,
    input  logic [CAP_W-1:0]                need,
    input  logic [CAP_W-1:0]                cap,
    input  logic [fpba_pkg::ID_W-1:0]       id,
    input  logic [IDX_W-1:0]                idx,
    output logic                            found,
    output logic [IDX_W-1:0]                best_idx,
    output logic [fpba_pkg::ID_W-1:0]       best_id,
    output logic [CAP_W-1:0]                remainder
);

    logic                      found_reg;
    logic [CAP_W-1:0]          best_cap_reg;
    logic [IDX_W-1:0]          best_idx_reg;
    logic [fpba_pkg::ID_W-1:0] best_id_reg;
    logic                      fits;
    logic                      take;

    // A strict compare keeps the earlier slot on equal capacities.
    always_comb
    begin
        fits = (cap >= need);
        take = fits && (!found_reg
            || (policy == fpba_pkg::POLICY_BEST && cap < best_cap_reg)
            || (policy == fpba_pkg::POLICY_WORST && cap > best_cap_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg    <= 1'b0;
            best_cap_reg <= '0;
            best_idx_reg <= '0;
            best_id_reg  <= '0;
        end
        else if (ctrl.clear)
        begin
            found_reg <= 1'b0;
        end
        else if (ctrl.step && take)
        begin
            found_reg    <= 1'b1;
            best_cap_reg <= cap;
            best_idx_reg <= idx;
            best_id_reg  <= id;
        end
    end

    assign found     = found_reg;
    assign best_idx  = best_idx_reg;
    assign best_id   = best_id_reg;
    assign remainder = best_cap_reg - need;

endmodule

`default_nettype wire

FILE: sv/fit_policy_block_allocator_core.sv
// Fit-policy block allocator.
// Items arrive on the req channel (valid/ready). A load beat writes a block id
// and size into a slot; loads can follow each other on consecutive cycles and
// give no response. A request beat scans slots 0 .. n-1, n being active_blocks
// capped at MAX_BLOCKS, one per cycle through a single compare unit and a
// memory with a registered read port, then writes the reduced capacity back
// when a slot fits. The response beat is registered from the finish state
// after the scan, and no new beat is accepted until the block is back in idle.
// The response sits in an output register; a stalled receiver lets the block
// keep taking loads, and a finished request waits until that register is free.
// Reset clears the control state and sets first fit with sixteen active slots.
// Slot contents are undefined after reset and must be loaded before a request
// scans them. Configuration is to be written over the APB port only while the
// block idles; the user is bound by this, and the block does not enforce it.
`default_nettype none

module fit_policy_block_allocator_core #(
    parameter int MAX_BLOCKS = 16,
    parameter int SIZE_BITS  = 20
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             req_valid,
    output logic                             req_ready,
    input  fpba_pkg::req_t                   req_data,
    output logic                             rsp_valid,
    input  logic                             rsp_ready,
    output fpba_pkg::rsp_t                   rsp_data,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [fpba_pkg::PADDR_W-1:0]     paddr,
    input  logic [fpba_pkg::PDATA_W-1:0]     pwdata,
    output logic [fpba_pkg::PDATA_W-1:0]     prdata,
    output logic                             pready
);

`include "fit_policy_block_allocator_core_defines.svh"

    localparam int IDX_W = $clog2(MAX_BLOCKS);
    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
    localparam int CMP_W = (CNT_W > fpba_pkg::ACTIVE_W) ? CNT_W : fpba_pkg::ACTIVE_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    state_t                              state_reg,      state_next;
    logic [CNT_W-1:0]                    addr_reg,       addr_next;
    logic                                pend_reg,       pend_next;
    logic [IDX_W-1:0]                    pend_idx_reg,   pend_idx_next;
    logic [CNT_W-1:0]                    n_reg,          n_next;
    logic [SIZE_BITS-1:0]                need_reg,       need_next;
    logic [fpba_pkg::ID_W-1:0]           tag_reg,        tag_next;
    logic [fpba_pkg::POLICY_W-1:0]       run_policy_reg, run_policy_next;
    logic                                rsp_valid_reg,  rsp_valid_next;
    fpba_pkg::rsp_t                      rsp_data_reg,   rsp_data_next;
    logic [fpba_pkg::POLICY_W-1:0]       fit_policy_reg, fit_policy_next;
    logic [fpba_pkg::ACTIVE_W-1:0]       active_reg,     active_next;

    fpba_pkg::mem_wr_t                   mem_wr;
    logic [IDX_W-1:0]                    mem_wr_addr;
    logic [SIZE_BITS-1:0]                mem_wr_cap;
    logic [fpba_pkg::ID_W-1:0]           mem_wr_id;
    logic                                mem_rd_en;
    logic [SIZE_BITS-1:0]                mem_rd_cap;
    logic [fpba_pkg::ID_W-1:0]           mem_rd_id;

    fpba_pkg::unit_ctrl_t                unit_ctrl;
    logic                                unit_found;
    logic [IDX_W-1:0]                    unit_best_idx;
    logic [fpba_pkg::ID_W-1:0]           unit_best_id;
    logic [SIZE_BITS-1:0]                unit_remainder;

    logic                                req_fire;
    logic                                cfg_write;
    logic [CNT_W-1:0]                    scan_count;

    fpba_slot_mem #(
        .DEPTH (MAX_BLOCKS),
        .CAP_W (SIZE_BITS)
    ) u_slot_mem (
        .clk     (clk),
        .wr      (mem_wr),
        .wr_addr (mem_wr_addr),
        .wr_cap  (mem_wr_cap),
        .wr_id   (mem_wr_id),
        .rd_en   (mem_rd_en),
        .rd_addr (addr_reg[IDX_W-1:0]),
        .rd_cap  (mem_rd_cap),
        .rd_id   (mem_rd_id)
    );

    fpba_fit_unit #(
        .CAP_W (SIZE_BITS),
        .IDX_W (IDX_W)
    ) u_fit_unit (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (unit_ctrl),
        .policy    (run_policy_reg),
        .need      (need_reg),
        .cap       (mem_rd_cap),
        .id        (mem_rd_id),
        .idx       (pend_idx_reg),
        .found     (unit_found),
        .best_idx  (unit_best_idx),
        .best_id   (unit_best_id),
        .remainder (unit_remainder)
    );

    assign req_ready = (state_reg == ST_IDLE);
    assign req_fire  = req_valid && req_ready;
    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;
    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

    always_comb
    begin
        if (CMP_W'(active_reg) > CMP_W'(MAX_BLOCKS))
        begin
            scan_count = CNT_W'(MAX_BLOCKS);
        end
        else
        begin
            scan_count = CNT_W'(active_reg);
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            fpba_pkg::REG_FIT_POLICY:    prdata = fpba_pkg::PDATA_W'(fit_policy_reg);
            fpba_pkg::REG_ACTIVE_BLOCKS: prdata = fpba_pkg::PDATA_W'(active_reg);
            default:                     prdata = '0;
        endcase
    end

    always_comb
    begin
        state_next      = state_reg;
        addr_next       = addr_reg;
        pend_next       = 1'b0;
        pend_idx_next   = pend_idx_reg;
        n_next          = n_reg;
        need_next       = need_reg;
        tag_next        = tag_reg;
        run_policy_next = run_policy_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp_ready;
        rsp_data_next   = rsp_data_reg;
        fit_policy_next = fit_policy_reg;
        active_next     = active_reg;
        mem_wr          = '0;
        mem_wr_addr     = IDX_W'(req_data.slot);
        mem_wr_cap      = SIZE_BITS'(req_data.amount);
        mem_wr_id       = req_data.block_id;
        mem_rd_en       = 1'b0;
        unit_ctrl       = '0;

        if (cfg_write)
        begin
            unique case (paddr[2])
                fpba_pkg::REG_FIT_POLICY:
                    fit_policy_next = pwdata[fpba_pkg::POLICY_W-1:0];
                fpba_pkg::REG_ACTIVE_BLOCKS:
                    active_next = pwdata[fpba_pkg::ACTIVE_W-1:0];
                default:
                    active_next = active_reg;
            endcase
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    if (req_data.kind == fpba_pkg::KIND_REQUEST)
                    begin
                        state_next      = ST_SCAN;
                        addr_next       = '0;
                        n_next          = scan_count;
                        need_next       = SIZE_BITS'(req_data.amount);
                        tag_next        = req_data.request_id;
                        run_policy_next = fit_policy_reg;
                        unit_ctrl.clear = 1'b1;
                    end
                    else if (int'(req_data.slot) < MAX_BLOCKS)
                    begin
                        mem_wr.we_cap = 1'b1;
                        mem_wr.we_id  = 1'b1;
                    end
                end
            end
            ST_SCAN:
            begin
                unit_ctrl.step = pend_reg;
                mem_rd_en      = (addr_reg != n_reg);
                if (mem_rd_en)
                begin
                    addr_next     = addr_reg + 1'b1;
                    pend_next     = 1'b1;
                    pend_idx_next = addr_reg[IDX_W-1:0];
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    state_next                  = ST_IDLE;
                    rsp_valid_next              = 1'b1;
                    rsp_data_next.request_tag   = tag_reg;
                    rsp_data_next.granted       = unit_found;
                    rsp_data_next.chosen_block  = '0;
                    rsp_data_next.capacity_left = '0;
                    if (unit_found)
                    begin
                        rsp_data_next.chosen_block  = unit_best_id;
                        rsp_data_next.capacity_left =
                            fpba_pkg::CAP_OUT_W'(unit_remainder);
                        mem_wr.we_cap = 1'b1;
                        mem_wr_addr   = unit_best_idx;
                        mem_wr_cap    = unit_remainder;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            addr_reg       <= '0;
            pend_reg       <= 1'b0;
            pend_idx_reg   <= '0;
            n_reg          <= '0;
            need_reg       <= '0;
            tag_reg        <= '0;
            run_policy_reg <= fpba_pkg::POLICY_FIRST;
            rsp_valid_reg  <= 1'b0;
            rsp_data_reg   <= '0;
            fit_policy_reg <= fpba_pkg::FIT_POLICY_RESET;
            active_reg     <= fpba_pkg::ACTIVE_BLOCKS_RESET;
        end
        else
        begin
            state_reg      <= state_next;
            addr_reg       <= addr_next;
            pend_reg       <= pend_next;
            pend_idx_reg   <= pend_idx_next;
            n_reg          <= n_next;
            need_reg       <= need_next;
            tag_reg        <= tag_next;
            run_policy_reg <= run_policy_next;
            rsp_valid_reg  <= rsp_valid_next;
            rsp_data_reg   <= rsp_data_next;
            fit_policy_reg <= fit_policy_next;
            active_reg     <= active_next;
        end
    end

    `FPBA_ASSERT_NEXT(a_request_blocks_input,
        req_valid && req_ready && req_data.kind == fpba_pkg::KIND_REQUEST,
        !req_ready)
    `FPBA_ASSERT_SAME(a_pick_within_scan, unit_found,
        CNT_W'(unit_best_idx) < n_reg)
    `FPBA_ASSERT_SAME(a_response_from_finish, $rose(rsp_valid),
        $past(state_reg == ST_FINISH))

endmodule

`default_nettype wire

FILE: sim/tb.sv
`default_nettype none

module tb;

    localparam int SLOTS           = 16;
    localparam int SETTLE_CYCLES   = 24;
    localparam int PHASE_ITEMS     = 192;
    localparam int PRESSURE_AT     = 400;
    localparam int PRESSURE_CYCLES = 300;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int REPORT_LIMIT    = 10;

    localparam logic [fpba_pkg::POLICY_W-1:0] POLICY_UNUSED = 2'd3;

    logic                          clk = 1'b0;
    logic                          rst_n;
    logic                          req_valid;
    logic                          req_ready;
    fpba_pkg::req_t                req_data;
    logic                          rsp_valid;
    logic                          rsp_ready;
    fpba_pkg::rsp_t                rsp_data;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [fpba_pkg::PADDR_W-1:0]  paddr;
    logic [fpba_pkg::PDATA_W-1:0]  pwdata;
    logic [fpba_pkg::PDATA_W-1:0]  prdata;
    logic                          pready;

    fpba_pkg::req_t item_queue[$];
    fpba_pkg::rsp_t expected_rsp[$];

    logic [fpba_pkg::AMOUNT_W-1:0] free_cap [SLOTS];
    logic [fpba_pkg::ID_W-1:0]     block_tag [SLOTS];
    logic [fpba_pkg::POLICY_W-1:0] cur_policy;
    logic [fpba_pkg::ACTIVE_W-1:0] cur_active;

    bit                            req_taken;
    bit                            idle_enabled;
    bit                            hold_rsp;
    int                            send_gap;
    int                            recv_gap;
    int                            errors;
    int                            loads_accepted;
    int                            requests_accepted;
    int                            grants_seen;
    int                            settings_used;
    int unsigned                   cycle_count;
    logic [fpba_pkg::AMOUNT_W-1:0] last_load_size;

    fit_policy_block_allocator_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_data  (rsp_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always #5 clk = ~clk;

    function automatic fpba_pkg::rsp_t allocate(fpba_pkg::req_t item);
        fpba_pkg::rsp_t                res;
        int                            scan;
        int                            pick;
        bit                            found;
        bit                            done;
        logic [fpba_pkg::AMOUNT_W-1:0] need;
        need  = item.amount;
        scan  = (cur_active > SLOTS) ? SLOTS : cur_active;
        pick  = 0;
        found = 1'b0;
        done  = 1'b0;
        for (int i = 0; i < scan && !done; i++)
        begin
            if (free_cap[i] >= need)
            begin
                if (!found)
                begin
                    found = 1'b1;
                    pick  = i;
                    done  = (cur_policy != fpba_pkg::POLICY_BEST)
                        && (cur_policy != fpba_pkg::POLICY_WORST);
                end
                else if (cur_policy == fpba_pkg::POLICY_BEST
                         && free_cap[i] < free_cap[pick])
                begin
                    pick = i;
                end
                else if (cur_policy == fpba_pkg::POLICY_WORST
                         && free_cap[i] > free_cap[pick])
                begin
                    pick = i;
                end
            end
        end
        res             = '0;
        res.request_tag = item.request_id;
        if (found)
        begin
            free_cap[pick]    = free_cap[pick] - need;
            res.granted       = 1'b1;
            res.chosen_block  = block_tag[pick];
            res.capacity_left = free_cap[pick];
        end
        return res;
    endfunction

    function automatic logic [fpba_pkg::AMOUNT_W-1:0] random_size();
        logic [fpba_pkg::AMOUNT_W-1:0] value;
        case ($urandom_range(0, 3))
            0:
            begin
                case ($urandom_range(0, 3))
                    0: value = '0;
                    1: value = 20'd1;
                    2: value = 20'hFFFFE;
                    default: value = 20'hFFFFF;
                endcase
            end
            1: value = 20'($urandom_range(0, 63));
            2: value = 20'($urandom_range(0, 4095));
            default: value = 20'($urandom);
        endcase
        return value;
    endfunction

    function automatic fpba_pkg::req_t make_item(logic [fpba_pkg::KIND_W-1:0] kind,
                                                 int slot, int id,
                                                 logic [fpba_pkg::AMOUNT_W-1:0] amount,
                                                 int rid);
        fpba_pkg::req_t item;
        item.kind       = kind;
        item.slot       = fpba_pkg::SLOT_W'(slot);
        item.block_id   = fpba_pkg::ID_W'(id);
        item.amount     = amount;
        item.request_id = fpba_pkg::ID_W'(rid);
        return item;
    endfunction

    task automatic report_fail(string msg);
        errors++;
        if (errors <= REPORT_LIMIT)
        begin
            $display("MISMATCH: %s", msg);
        end
    endtask

    task automatic check_field(string field, longint unsigned want, longint unsigned got,
                               logic [fpba_pkg::ID_W-1:0] tag);
        if (want !== got)
        begin
            report_fail($sformatf("request %h %s expected %h got %h", tag, field, want, got));
        end
    endtask

    task automatic write_reg(logic idx, logic [fpba_pkg::PDATA_W-1:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic wait_idle();
        while (item_queue.size() != 0 || req_valid || expected_rsp.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic run_phase(logic [fpba_pkg::POLICY_W-1:0] policy, int active, bit calm);
        fpba_pkg::req_t                item;
        logic [fpba_pkg::AMOUNT_W-1:0] amount;
        wait_idle();
        write_reg(fpba_pkg::REG_FIT_POLICY, fpba_pkg::PDATA_W'(policy));
        write_reg(fpba_pkg::REG_ACTIVE_BLOCKS, fpba_pkg::PDATA_W'(active));
        cur_policy   = policy;
        cur_active   = fpba_pkg::ACTIVE_W'(active);
        idle_enabled = !calm;
        settings_used++;
        for (int n = 0; n < PHASE_ITEMS; n++)
        begin
            if ($urandom_range(0, 9) < 4)
            begin
                amount = ($urandom_range(0, 3) == 0) ? last_load_size : random_size();
                last_load_size = amount;
                item = make_item(fpba_pkg::KIND_LOAD, $urandom_range(0, SLOTS - 1),
                                 $urandom_range(0, 16'hFFFF), amount,
                                 $urandom_range(0, 16'hFFFF));
            end
            else
            begin
                case ($urandom_range(0, 9))
                    0: amount = '0;
                    1, 2, 3: amount = random_size();
                    default: amount = 20'($urandom_range(0, 255));
                endcase
                item = make_item(fpba_pkg::KIND_REQUEST, $urandom_range(0, SLOTS - 1),
                                 $urandom_range(0, 16'hFFFF), amount,
                                 $urandom_range(0, 16'hFFFF));
            end
            item_queue.push_back(item);
        end
    endtask

    always @(posedge clk)
    begin
        fpba_pkg::rsp_t want;
        req_taken = rst_n && req_valid && req_ready;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (expected_rsp.size() == 0)
            begin
                report_fail($sformatf("result beat with no request pending, tag %h",
                                      rsp_data.request_tag));
            end
            else
            begin
                want = expected_rsp.pop_front();
                if (want.granted)
                begin
                    grants_seen++;
                end
                check_field("request_tag", want.request_tag, rsp_data.request_tag,
                            want.request_tag);
                check_field("granted", want.granted, rsp_data.granted, want.request_tag);
                check_field("chosen_block", want.chosen_block, rsp_data.chosen_block,
                            want.request_tag);
                check_field("capacity_left", want.capacity_left, rsp_data.capacity_left,
                            want.request_tag);
            end
        end
        if (req_taken)
        begin
            if (req_data.kind == fpba_pkg::KIND_LOAD)
            begin
                free_cap[req_data.slot]  = req_data.amount;
                block_tag[req_data.slot] = req_data.block_id;
                loads_accepted++;
            end
            else
            begin
                expected_rsp.push_back(allocate(req_data));
                requests_accepted++;
            end
        end
    end

    always @(negedge clk)
    begin
        if (rst_n && (!req_valid || req_taken))
        begin
            if (send_gap > 0)
            begin
                send_gap--;
                req_valid <= 1'b0;
            end
            else if (idle_enabled && $urandom_range(0, 7) == 0)
            begin
                send_gap = $urandom_range(0, 9);
                req_valid <= 1'b0;
            end
            else if (item_queue.size() != 0)
            begin
                req_data  <= item_queue.pop_front();
                req_valid <= 1'b1;
            end
            else
            begin
                req_valid <= 1'b0;
            end
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_rsp)
            begin
                rsp_ready <= 1'b0;
            end
            else if (recv_gap > 0)
            begin
                recv_gap--;
                rsp_ready <= 1'b0;
            end
            else if (idle_enabled && $urandom_range(0, 7) == 0)
            begin
                recv_gap = $urandom_range(0, 9);
                rsp_ready <= 1'b0;
            end
            else
            begin
                rsp_ready <= 1'b1;
            end
        end
    end

    initial
    begin
        wait (requests_accepted >= PRESSURE_AT);
        @(posedge clk);
        hold_rsp = 1'b1;
        repeat (PRESSURE_CYCLES) @(posedge clk);
        hold_rsp = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        rst_n          = 1'b0;
        req_valid      = 1'b0;
        req_data       = '0;
        rsp_ready      = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        cur_policy     = fpba_pkg::FIT_POLICY_RESET;
        cur_active     = fpba_pkg::ACTIVE_BLOCKS_RESET;
        idle_enabled   = 1'b1;
        last_load_size = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            free_cap[i]  = '0;
            block_tag[i] = '0;
        end
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Fill every slot before any scan, with ties in size across several slots.
        for (int i = 0; i < SLOTS; i++)
        begin
            item_queue.push_back(make_item(fpba_pkg::KIND_LOAD, i, i * 16'h1111,
                                           (i == 0) ? 20'hFFFFF :
                                           (i == 1) ? 20'd0 : 20'((i % 4 + 1) * 100),
                                           16'h5A5A));
        end
        item_queue.push_back(make_item(fpba_pkg::KIND_REQUEST, 0, 0, 20'd0, 16'hFFFF));
        item_queue.push_back(make_item(fpba_pkg::KIND_REQUEST, 15, 16'hFFFF, 20'hFFFFF,
                                       16'h0000));
        item_queue.push_back(make_item(fpba_pkg::KIND_REQUEST, 0, 0, 20'hFFFFF, 16'h0001));
        item_queue.push_back(make_item(fpba_pkg::KIND_REQUEST, 0, 0, 20'd0, 16'h0002));
        item_queue.push_back(make_item(fpba_pkg::KIND_REQUEST, 0, 0, 20'd150, 16'h0003));
        item_queue.push_back(make_item(fpba_pkg::KIND_REQUEST, 0, 0, 20'd400, 16'h0004));
        item_queue.push_back(make_item(fpba_pkg::KIND_REQUEST, 0, 0, 20'd401, 16'h8000));

        run_phase(fpba_pkg::POLICY_BEST, 16, 1'b0);
        run_phase(fpba_pkg::POLICY_WORST, 16, 1'b0);
        run_phase(POLICY_UNUSED, 16, 1'b0);
        run_phase(fpba_pkg::POLICY_BEST, 1, 1'b0);
        run_phase(fpba_pkg::POLICY_WORST, 31, 1'b1);
        run_phase(fpba_pkg::POLICY_FIRST, 0, 1'b0);
        run_phase(fpba_pkg::POLICY_BEST, 5, 1'b0);
        run_phase(fpba_pkg::POLICY_WORST, 16, 1'b0);
        run_phase(fpba_pkg::POLICY_FIRST, 16, 1'b0);
        run_phase(fpba_pkg::POLICY_BEST, 16, 1'b1);
        wait_idle();

        if (expected_rsp.size() != 0)
        begin
            report_fail($sformatf("%0d results never arrived", expected_rsp.size()));
        end
        $display("Run covered %0d load beats and %0d requests, %0d of them granted,",
                 loads_accepted, requests_accepted, grants_seen);
        $display("across %0d register settings of fit policy and active slot count.",
                 settings_used + 1);
        if (errors == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire

FILE: fit_policy_block_allocator_core.f
+incdir+sv
sv/fpba_pkg.sv
sv/fpba_slot_mem.sv
sv/fpba_fit_unit.sv
sv/fit_policy_block_allocator_core.sv
sim/tb.sv
